// File: src/rem_pkg.sv
// rem_pkg: shared types, codes and an angle helper for the exploration controller.
// No dependencies; imported by every module of the block.
package rem_pkg;

	localparam int TURN_UNITS = 5760;
	localparam int HALF_TURN  = 2880;

	localparam int ANG_W   = 13;
	localparam int DIST_W  = 16;
	localparam int IR_W    = 12;
	localparam int SPEED_W = 10;
	localparam int TURN_W  = 11;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 3;
	localparam int CFGD_W  = 16;
	localparam int IN_DW   = 56;
	localparam int OUT_DW  = 24;

	typedef enum logic [2:0] {
		MODE_CHECK_DOCK = 3'd0,
		MODE_UNDOCKING  = 3'd1,
		MODE_SCANNING   = 3'd2,
		MODE_ROTATING   = 3'd3,
		MODE_WALKING    = 3'd4,
		MODE_FINISHED   = 3'd5
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		K_TICK   = 3'd0,
		K_DOCK   = 3'd1,
		K_UNDOCK = 3'd2,
		K_HAZARD = 3'd3,
		K_IR     = 3'd4,
		K_ODOM   = 3'd5,
		K_SCAN   = 3'd6
	} kind_t;

	// register indexes on the config port
	localparam logic [IDX_W-1:0] CFG_STOP_DIST  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_IR_THRESH  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_ANGLE_TOL  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_WALK_SPEED = 3'd3;
	localparam logic [IDX_W-1:0] CFG_TURN_SPEED = 3'd4;
	localparam logic [IDX_W-1:0] CFG_TIMEOUT    = 3'd5;

	typedef struct packed {
		logic [12:0] stop_distance_mm;
		logic [11:0] ir_threshold;
		logic [11:0] heading_tol;
		logic [9:0]  walk_speed;
		logic [9:0]  turn_speed;
		logic [15:0] discovery_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic              event_flag;
		logic [IR_W-1:0]   ir_value;
		logic [ANG_W-1:0]  yaw_angle;      // already reduced to one turn
		logic [DIST_W-1:0] frontal_distance;
		logic [ANG_W-1:0]  target_bearing; // already reduced to one turn
	} item_t;

	// one compare-subtract; valid for v below two turns
	function automatic logic [ANG_W-1:0] fold_turn(input logic [ANG_W:0] v);
		logic [ANG_W:0] r;
		begin
			r = (v >= (ANG_W+1)'(TURN_UNITS)) ? v - (ANG_W+1)'(TURN_UNITS) : v;
			fold_turn = r[ANG_W-1:0];
		end
	endfunction

endpackage

// File: src/rem_cfg_regs.sv
// rem_cfg_regs: configuration register file, write-only, reset to defaults.
// Depends on rem_pkg.
module rem_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rem_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rem_pkg::CFGD_W-1:0] cfg_data,
	output rem_pkg::cfg_t             cfg
);
	import rem_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_distance_mm        <= 13'd500;
			cfg_q.ir_threshold            <= 12'd200;
			cfg_q.heading_tol             <= 12'd32;
			cfg_q.walk_speed              <= 10'd300;
			cfg_q.turn_speed              <= 10'd500;
			cfg_q.discovery_timeout_ticks <= 16'd4000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STOP_DIST:  cfg_q.stop_distance_mm        <= cfg_data[12:0];
				CFG_IR_THRESH:  cfg_q.ir_threshold            <= cfg_data[11:0];
				CFG_ANGLE_TOL:  cfg_q.heading_tol             <= cfg_data[11:0];
				CFG_WALK_SPEED: cfg_q.walk_speed              <= cfg_data[9:0];
				CFG_TURN_SPEED: cfg_q.turn_speed              <= cfg_data[9:0];
				CFG_TIMEOUT:    cfg_q.discovery_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/rem_in_reg.sv
// rem_in_reg: input stage; unpacks the beat, folds angles into one turn, registers it.
// Depends on rem_pkg.
module rem_in_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [rem_pkg::IN_DW-1:0]  s_axis_tdata,
	input  logic [rem_pkg::KIND_W-1:0] s_axis_tuser,
	input  logic                      adv,
	output logic                      valid_s1,
	output rem_pkg::item_t            item_s1
);
	import rem_pkg::*;

	item_t item_d;
	logic  vld_s1;

	always_comb begin
		item_d.kind             = kind_t'(s_axis_tuser);
		item_d.event_flag       = s_axis_tdata[0];
		item_d.ir_value         = s_axis_tdata[12:1];
		item_d.yaw_angle        = fold_turn({1'b0, s_axis_tdata[25:13]});
		item_d.frontal_distance = s_axis_tdata[41:26];
		item_d.target_bearing   = fold_turn({1'b0, s_axis_tdata[54:42]});
	end

	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_d;
		end
	end

	assign valid_s1 = vld_s1;

endmodule

// File: src/rem_core.sv
// rem_core: mode machine, sensor state and the result register.
// Depends on rem_pkg; fed by rem_in_reg and rem_cfg_regs.
module rem_core #(
	parameter int MIN_CELLS = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rem_pkg::cfg_t              cfg,
	input  logic                       valid_s1,
	input  rem_pkg::item_t             item_s1,
	output logic                       adv,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [rem_pkg::OUT_DW-1:0]  m_axis_tdata,
	output logic                       m_axis_tlast
);
	import rem_pkg::*;

	localparam int CW = $clog2(MIN_CELLS + 2);
	localparam logic signed [ANG_W:0] HALF_S = (ANG_W+1)'(HALF_TURN);
	localparam logic signed [ANG_W:0] TURN_S = (ANG_W+1)'(TURN_UNITS);

	mode_t              mode_q, mode_n;
	logic               hazard_q, hazard_n;
	logic               scan_q, scan_n;
	logic               odom_q, odom_n;
	logic [CW-1:0]      cells_q, cells_n;
	logic [15:0]        ticks_q, ticks_n;
	logic [ANG_W-1:0]   head_q, head_n;
	logic [DIST_W-1:0]  gap_q, gap_n;
	logic [ANG_W-1:0]   bear_q, bear_n;
	logic [ANG_W-1:0]   goal_q, goal_n;

	logic               res_vld_q;
	logic [SPEED_W-1:0] lin_q;
	logic [TURN_W-1:0]  ang_q;
	logic               done_q;

	logic               go, active, quiet, tick_live;
	logic [15:0]        ticks_inc;
	logic               timeout_hit, near, stop_hit;
	logic signed [ANG_W:0] diff_raw, diff;
	logic [ANG_W-1:0]   mag;
	logic               aligned;
	logic               emit;
	logic [SPEED_W-1:0] lin_d;
	logic [TURN_W-1:0]  ang_d;
	logic               done_d;

	assign adv = !res_vld_q || m_axis_tready;
	assign go  = valid_s1 && adv && (mode_q != MODE_FINISHED);

	assign active = (mode_q == MODE_SCANNING) || (mode_q == MODE_ROTATING)
		|| (mode_q == MODE_WALKING);
	assign quiet  = !active || !scan_q;
	assign tick_live = go && (item_s1.kind == K_TICK) && !quiet;

	assign ticks_inc = (odom_q && ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
	assign timeout_hit = odom_q && (cells_q > CW'(MIN_CELLS))
		&& (ticks_inc > cfg.discovery_timeout_ticks);
	assign near     = (mode_q == MODE_WALKING) && (gap_q < {3'b000, cfg.stop_distance_mm});
	assign stop_hit = hazard_q || near;

	// wrapped heading error into [-half turn, +half turn], signed compares
	assign diff_raw = $signed({1'b0, goal_q}) - $signed({1'b0, head_q});
	always_comb begin
		diff = diff_raw;
		if (diff_raw > HALF_S) begin
			diff = diff_raw - TURN_S;
		end else if (diff_raw < -HALF_S) begin
			diff = diff_raw + TURN_S;
		end
	end
	assign mag     = diff[ANG_W] ? ANG_W'(-diff) : diff[ANG_W-1:0];
	assign aligned = mag <= {1'b0, cfg.heading_tol};

	// next state
	always_comb begin
		mode_n   = mode_q;
		hazard_n = hazard_q;
		scan_n   = scan_q;
		odom_n   = odom_q;
		cells_n  = cells_q;
		ticks_n  = ticks_q;
		head_n   = head_q;
		gap_n    = gap_q;
		bear_n   = bear_q;
		goal_n   = goal_q;
		if (go) begin
			case (item_s1.kind)
				K_TICK: begin
					ticks_n = ticks_inc;
					if (!quiet) begin
						if (timeout_hit) begin
							mode_n = MODE_FINISHED;
						end else if (stop_hit) begin
							if (mode_q != MODE_SCANNING) mode_n = MODE_SCANNING;
							hazard_n = 1'b0;
						end else if (mode_q == MODE_SCANNING) begin
							goal_n = fold_turn({1'b0, bear_q} + {1'b0, head_q});
							mode_n = MODE_ROTATING;
						end else if (mode_q == MODE_ROTATING && aligned) begin
							mode_n = MODE_WALKING;
						end
					end
				end
				K_DOCK: begin
					if (mode_q == MODE_CHECK_DOCK) begin
						mode_n = item_s1.event_flag ? MODE_UNDOCKING : MODE_SCANNING;
					end
				end
				K_UNDOCK: begin
					if (mode_q == MODE_UNDOCKING && item_s1.event_flag) mode_n = MODE_SCANNING;
				end
				K_HAZARD: begin
					if (active && item_s1.event_flag) hazard_n = 1'b1;
				end
				K_IR: begin
					if (active && item_s1.ir_value > cfg.ir_threshold) hazard_n = 1'b1;
				end
				K_ODOM: begin
					odom_n = 1'b1;
					if (!odom_q) ticks_n = 16'd0;
					head_n = item_s1.yaw_angle;
					if (item_s1.event_flag) begin
						if (cells_q < CW'(MIN_CELLS + 1)) cells_n = cells_q + CW'(1);
						ticks_n = 16'd0;
					end
				end
				K_SCAN: begin
					gap_n  = item_s1.frontal_distance;
					bear_n = item_s1.target_bearing;
					scan_n = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result of a live tick
	always_comb begin
		emit   = 1'b0;
		lin_d  = '0;
		ang_d  = '0;
		done_d = 1'b0;
		if (tick_live) begin
			if (timeout_hit) begin
				emit   = 1'b1;
				done_d = 1'b1;
			end else if (stop_hit) begin
				emit = 1'b1;
			end else if (mode_q == MODE_ROTATING) begin
				emit = 1'b1;
				if (!aligned) begin
					ang_d = diff[ANG_W] ? -{1'b0, cfg.turn_speed} : {1'b0, cfg.turn_speed};
				end
			end else if (mode_q == MODE_WALKING) begin
				emit  = 1'b1;
				lin_d = cfg.walk_speed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_CHECK_DOCK;
			hazard_q  <= 1'b0;
			scan_q    <= 1'b0;
			odom_q    <= 1'b0;
			cells_q   <= '0;
			ticks_q   <= '0;
			head_q    <= '0;
			gap_q     <= 16'hFFFF;
			bear_q    <= '0;
			goal_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			mode_q   <= mode_n;
			hazard_q <= hazard_n;
			scan_q   <= scan_n;
			odom_q   <= odom_n;
			cells_q  <= cells_n;
			ticks_q  <= ticks_n;
			head_q   <= head_n;
			gap_q    <= gap_n;
			bear_q   <= bear_n;
			goal_q   <= goal_n;
			if (adv) res_vld_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			lin_q  <= lin_d;
			ang_q  <= ang_d;
			done_q <= done_d;
		end
	end

	assign m_axis_tvalid = res_vld_q;
	assign m_axis_tdata  = {{(OUT_DW - SPEED_W - TURN_W){1'b0}}, ang_q, lin_q};
	assign m_axis_tlast  = done_q;

endmodule

// File: src/reactive_explore_motion_fsm.sv
// Exploration controller for a mobile robot: mode machine that turns sensor
// and timer beats into velocity commands.
// Mode and sensor state update at once, the command goes to the result register.
// Throughput: one beat per cycle while the command output is not stalled.
// Reset (arst_n low, asynchronous): check-dock mode, sensor state cleared and the gap
// at its maximum, registers at their defaults, both pipeline stages empty.
module reactive_explore_motion_fsm #(
	parameter int MIN_CELLS = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_we,
	input  logic [rem_pkg::IDX_W-1:0]   cfg_index,
	input  logic [rem_pkg::CFGD_W-1:0]  cfg_data,
	// event beats
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// event_flag[0], ir_value[12:1], yaw_angle[25:13], frontal_distance[41:26],
	// target_bearing[54:42], zero[55]
	input  logic [rem_pkg::IN_DW-1:0]   s_axis_tdata,
	// kind[2:0]
	input  logic [rem_pkg::KIND_W-1:0]  s_axis_tuser,
	// command beats
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// linear_speed[9:0], angular_speed[20:10] (two's complement), zero[23:21]
	output logic [rem_pkg::OUT_DW-1:0]  m_axis_tdata,
	// mission_done: set only on the final stop command
	output logic                       m_axis_tlast
);
	import rem_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  adv;

	// Register file; the user writes it only while no beat is in flight (unchecked).
	rem_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: input register. It refills whenever the core consumes its
	// beat, so a stalled command output only back-pressures once both the
	// result register and this stage are full.
	rem_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.adv           (adv),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	// Stage 2: mode machine and sensor state update together, the
	// command (if any) lands in the result register. Beats that give no
	// command pass through without occupying it.
	rem_core #(
		.MIN_CELLS (MIN_CELLS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: src/rem_checker.sv
// rem_checker: port-level properties of the exploration controller, bound to the top.
// Depends on rem_pkg and reactive_explore_motion_fsm.
module rem_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [rem_pkg::OUT_DW-1:0] m_axis_tdata,
	input logic                      m_axis_tlast
);
	import rem_pkg::*;

	// stalled command holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("command changed while stalled");

	// never drive and turn at once; pad bits stay zero
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[9:0] == 10'd0 || m_axis_tdata[20:10] == 11'd0)
			&& m_axis_tdata[23:21] == 3'd0)
		else $error("linear and angular both nonzero");

	// final command is a full stop
	a_final_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[20:0] == 21'd0)
		else $error("mission end without stop");

	// nothing follows the final command
	a_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("command after mission end");

endmodule

bind reactive_explore_motion_fsm rem_checker u_rem_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
